>>> rtl/core/ppd_pkg.sv
package ppd_pkg;

  // default sizes of the block
  localparam int WINDOW_RADIUS_DEF = 3;
  localparam int FRAME_BITS_DEF    = 20;
  localparam int FRAC_BITS_DEF     = 8;
  localparam int LOGIT_BITS_DEF    = 16;

  // merge distance register
  localparam int              MW_BITS           = 4;
  localparam logic [MW_BITS-1:0] MERGE_WIDTH_RESET = 4'd1;

  // entries of the event queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // event kinds carried through the queue
  localparam logic EV_PEAK  = 1'b0;
  localparam logic EV_FINAL = 1'b1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_JUDGE,
    F_FINAL
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_APPLY
  } back_state_t;

endpackage

>>> rtl/core/ppd_queue.sv
module ppd_queue #(
  parameter int WIDTH = 21,
  parameter int DEPTH = ppd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    data [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  // status toward both sides
  assign push_ready = (count != CNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = data[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      data[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ppd_front.sv
module ppd_front #(
  parameter int WINDOW_RADIUS = ppd_pkg::WINDOW_RADIUS_DEF,
  parameter int FRAME_BITS    = ppd_pkg::FRAME_BITS_DEF,
  parameter int LOGIT_BITS    = ppd_pkg::LOGIT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [LOGIT_BITS-1:0] logit,
  input  logic                         is_last,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic                         push,
  output logic                         push_kind,
  output logic [FRAME_BITS-1:0]        push_frame,
  input  logic                         push_ready
);

  localparam int WIN_LEN = 2 * WINDOW_RADIUS + 1;
  localparam int FC_BITS = $clog2(WINDOW_RADIUS + 1);

  ppd_pkg::front_state_t state, state_next;

  logic signed [LOGIT_BITS-1:0] win_val [WIN_LEN];
  logic [WIN_LEN-1:0]           win_vld;
  logic [FRAME_BITS-1:0]        frame_count;
  logic [FRAME_BITS-1:0]        judge_frame;
  logic                         last_pend;
  logic [FC_BITS-1:0]           flush_cnt;

  logic accept;
  logic peak;
  logic advance;
  logic flush_done;
  logic flush_shift;
  logic seq_clear;

  assign accept     = in_valid && in_ready;
  assign flush_done = (flush_cnt == FC_BITS'(WINDOW_RADIUS));
  assign push_frame = judge_frame;

  // centre slot is a peak when valid, positive and not below any valid slot
  always_comb begin
    peak = win_vld[WINDOW_RADIUS] && !win_val[WINDOW_RADIUS][LOGIT_BITS-1]
           && (win_val[WINDOW_RADIUS] != '0);
    for (int k = 0; k < WIN_LEN; k++) begin
      if (win_vld[k] && (win_val[k] > win_val[WINDOW_RADIUS])) begin
        peak = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppd_pkg::F_IDLE: begin
        if (accept) begin
          state_next = ppd_pkg::F_JUDGE;
        end
      end
      ppd_pkg::F_JUDGE: begin
        if (advance && !(last_pend && !flush_done)) begin
          state_next = last_pend ? ppd_pkg::F_FINAL : ppd_pkg::F_IDLE;
        end
      end
      ppd_pkg::F_FINAL: begin
        if (push_ready) begin
          state_next = ppd_pkg::F_IDLE;
        end
      end
      default: state_next = ppd_pkg::F_IDLE;
    endcase
  end

  // outputs and step controls
  always_comb begin
    in_ready    = 1'b0;
    push        = 1'b0;
    push_kind   = ppd_pkg::EV_PEAK;
    advance     = 1'b0;
    flush_shift = 1'b0;
    seq_clear   = 1'b0;
    case (state)
      ppd_pkg::F_IDLE: begin
        in_ready = 1'b1;
      end
      ppd_pkg::F_JUDGE: begin
        push        = peak;
        advance     = !peak || push_ready;
        flush_shift = advance && last_pend && !flush_done;
      end
      ppd_pkg::F_FINAL: begin
        push      = 1'b1;
        push_kind = ppd_pkg::EV_FINAL;
        seq_clear = push_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // window values, shifted in on a transfer or a flush step
  always_ff @(posedge clk) begin
    if (accept) begin
      win_val[0] <= logit;
    end else if (flush_shift) begin
      win_val[0] <= '0;
    end
    if (accept || flush_shift) begin
      for (int k = 1; k < WIN_LEN; k++) begin
        win_val[k] <= win_val[k-1];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ppd_pkg::F_IDLE;
      win_vld     <= '0;
      frame_count <= '0;
      judge_frame <= '0;
      last_pend   <= 1'b0;
      flush_cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        win_vld     <= {win_vld[WIN_LEN-2:0], 1'b1};
        judge_frame <= frame_count - FRAME_BITS'(WINDOW_RADIUS);
        frame_count <= frame_count + 1'b1;
        last_pend   <= is_last;
        flush_cnt   <= '0;
      end
      if (flush_shift) begin
        win_vld     <= {win_vld[WIN_LEN-2:0], 1'b0};
        judge_frame <= judge_frame + 1'b1;
        flush_cnt   <= flush_cnt + 1'b1;
      end
      if (seq_clear) begin
        win_vld     <= '0;
        frame_count <= '0;
        last_pend   <= 1'b0;
        flush_cnt   <= '0;
      end
    end
  end

endmodule

>>> rtl/core/ppd_back.sv
module ppd_back #(
  parameter int FRAME_BITS = ppd_pkg::FRAME_BITS_DEF,
  parameter int FRAC_BITS  = ppd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ppd_pkg::MW_BITS-1:0]       cfg_wr_data,
  input  logic                              ev_valid,
  input  logic                              ev_kind,
  input  logic [FRAME_BITS-1:0]             ev_frame,
  output logic                              ev_pop,
  output logic [FRAME_BITS+FRAC_BITS-1:0]   mean_frame,
  output logic                              has_peak,
  output logic                              final_res,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int MB        = FRAME_BITS + FRAC_BITS;
  localparam int STEP_BITS = $clog2(MB);

  ppd_pkg::back_state_t state, state_next;

  logic [ppd_pkg::MW_BITS-1:0] merge_width;
  logic [MB-1:0]               mean;
  logic [FRAME_BITS-1:0]       count;
  logic                        open;
  logic [FRAME_BITS-1:0]       rem;
  logic [MB-1:0]               quo;
  logic                        neg;
  logic [STEP_BITS-1:0]        step;

  logic [MB-1:0]         pq;
  logic [MB:0]           diff;
  logic [MB:0]           lim;
  logic                  merge;
  logic [MB:0]           diff_abs;
  logic [FRAME_BITS-1:0] count_inc;
  logic [FRAME_BITS:0]   shifted;
  logic                  ge;
  logic [FRAME_BITS:0]   trial;
  logic                  out_free;

  logic                  new_group;
  logic                  div_start;
  logic                  emit;
  logic [MB-1:0]         emit_mean;
  logic                  emit_has;
  logic                  emit_fin;
  logic                  group_clear;

  // merge test on the event at the queue head
  assign pq        = MB'(ev_frame) << FRAC_BITS;
  assign diff      = {1'b0, pq} - {1'b0, mean};
  assign lim       = (MB + 1)'(merge_width) << FRAC_BITS;
  assign merge     = ($signed(diff) <= $signed(lim));
  assign diff_abs  = diff[MB] ? (~diff + 1'b1) : diff;
  assign count_inc = (count != '1) ? count + 1'b1 : count;
  assign out_free  = !out_valid || out_ready;

  // one quotient bit per cycle
  assign shifted = {rem, quo[MB-1]};
  assign ge      = (shifted >= {1'b0, count});
  assign trial   = shifted - {1'b0, count};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ppd_pkg::B_IDLE: begin
        if (div_start) begin
          state_next = ppd_pkg::B_DIV;
        end
      end
      ppd_pkg::B_DIV: begin
        if (step == STEP_BITS'(MB - 1)) begin
          state_next = ppd_pkg::B_APPLY;
        end
      end
      ppd_pkg::B_APPLY: begin
        state_next = ppd_pkg::B_IDLE;
      end
      default: state_next = ppd_pkg::B_IDLE;
    endcase
  end

  // event handling
  always_comb begin
    ev_pop      = 1'b0;
    new_group   = 1'b0;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_mean   = mean;
    emit_has    = 1'b1;
    emit_fin    = 1'b0;
    group_clear = 1'b0;
    case (state)
      ppd_pkg::B_IDLE: begin
        if (ev_valid) begin
          if (ev_kind == ppd_pkg::EV_FINAL) begin
            if (out_free) begin
              ev_pop      = 1'b1;
              emit        = 1'b1;
              emit_mean   = open ? mean : '0;
              emit_has    = open;
              emit_fin    = 1'b1;
              group_clear = 1'b1;
            end
          end else if (!open) begin
            ev_pop    = 1'b1;
            new_group = 1'b1;
          end else if (merge) begin
            ev_pop    = 1'b1;
            div_start = 1'b1;
          end else if (out_free) begin
            ev_pop    = 1'b1;
            emit      = 1'b1;
            new_group = 1'b1;
          end
        end
      end
      default: begin
        ev_pop = 1'b0;
      end
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (div_start) begin
      rem  <= '0;
      quo  <= diff_abs[MB-1:0];
      neg  <= diff[MB];
      step <= '0;
    end else if (state == ppd_pkg::B_DIV) begin
      rem  <= ge ? trial[FRAME_BITS-1:0] : shifted[FRAME_BITS-1:0];
      quo  <= {quo[MB-2:0], ge};
      step <= step + 1'b1;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      mean_frame <= emit_mean;
      has_peak   <= emit_has;
      final_res  <= emit_fin;
    end
  end

  // group state, register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ppd_pkg::B_IDLE;
      merge_width <= ppd_pkg::MERGE_WIDTH_RESET;
      mean        <= '0;
      count       <= '0;
      open        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        merge_width <= cfg_wr_data;
      end
      if (new_group) begin
        mean  <= pq;
        count <= FRAME_BITS'(1);
        open  <= 1'b1;
      end
      if (div_start) begin
        count <= count_inc;
      end
      if (state == ppd_pkg::B_APPLY) begin
        mean <= neg ? mean - quo : mean + quo;
      end
      if (group_clear) begin
        mean  <= '0;
        count <= '0;
        open  <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/peak_pick_dedup.sv
// Peak picker with merging of nearby peaks.
// Input transfer: one signed logit per frame on logit, with is_last marking
// the final frame of a sequence (in_valid / in_ready).
// Output transfer: mean_frame (group mean in frames, fraction bits below),
// has_peak and final_res (out_valid / out_ready).
// merge_width is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, and the block does not enforce this. The front
// judges each frame before it takes the next, and waits while a peak finds
// its event queue full; a last frame holds it while the window is flushed
// and the end event is queued. The back merges a peak with a restoring
// divider that yields one quotient bit per cycle and takes no new event
// until the divide and the mean update are done; a new or closing group is
// handled while idle. A result is registered once the output is free.
// Reset (synchronous) clears the window, counters, open group and queue and
// sets merge_width to 1. A stalled receiver holds the output register; the
// back then waits, the queue fills and in_ready drops.
module peak_pick_dedup #(
  parameter int WINDOW_RADIUS = ppd_pkg::WINDOW_RADIUS_DEF,
  parameter int FRAME_BITS    = ppd_pkg::FRAME_BITS_DEF,
  parameter int FRAC_BITS     = ppd_pkg::FRAC_BITS_DEF,
  parameter int LOGIT_BITS    = ppd_pkg::LOGIT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ppd_pkg::MW_BITS-1:0]     cfg_wr_data,
  input  logic signed [LOGIT_BITS-1:0]    logit,
  input  logic                            is_last,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic [FRAME_BITS+FRAC_BITS-1:0] mean_frame,
  output logic                            has_peak,
  output logic                            final_res,
  output logic                            out_valid,
  input  logic                            out_ready
);

  logic                  push;
  logic                  push_kind;
  logic [FRAME_BITS-1:0] push_frame;
  logic                  push_ready;
  logic                  ev_pop;
  logic                  ev_valid;
  logic [FRAME_BITS:0]   ev_data;

  // window and peak judgement
  ppd_front #(
    .WINDOW_RADIUS (WINDOW_RADIUS),
    .FRAME_BITS    (FRAME_BITS),
    .LOGIT_BITS    (LOGIT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .logit      (logit),
    .is_last    (is_last),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push       (push),
    .push_kind  (push_kind),
    .push_frame (push_frame),
    .push_ready (push_ready)
  );

  // peak and end events between the two sides
  ppd_queue #(
    .WIDTH (FRAME_BITS + 1),
    .DEPTH (ppd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_kind, push_frame}),
    .push_ready (push_ready),
    .pop        (ev_pop),
    .pop_data   (ev_data),
    .pop_valid  (ev_valid)
  );

  // group merging and result output
  ppd_back #(
    .FRAME_BITS (FRAME_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ev_valid    (ev_valid),
    .ev_kind     (ev_data[FRAME_BITS]),
    .ev_frame    (ev_data[FRAME_BITS-1:0]),
    .ev_pop      (ev_pop),
    .mean_frame  (mean_frame),
    .has_peak    (has_peak),
    .final_res   (final_res),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

endmodule

>>> test/peak_pick_dedup_tb.sv
`timescale 1ns / 100ps

module peak_pick_dedup_tb;

  localparam int WR            = ppd_pkg::WINDOW_RADIUS_DEF;
  localparam int WIN_LEN       = 2 * WR + 1;
  localparam int FB            = ppd_pkg::FRAME_BITS_DEF;
  localparam int FR            = ppd_pkg::FRAC_BITS_DEF;
  localparam int MB            = FB + FR;
  localparam int LB            = ppd_pkg::LOGIT_BITS_DEF;
  localparam int BURST_FRAMES  = 16;
  localparam int RANDOM_FRAMES = 260;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 30;
  localparam int TIMEOUT_NS    = 10_000_000;

  typedef struct packed {
    logic [MB-1:0] mean;
    logic          peak;
    logic          fin;
  } group_res_t;

  typedef struct packed {
    logic                        cfg;
    logic [ppd_pkg::MW_BITS-1:0] mw;
    logic [LB-1:0]               lg;
    logic                        lst;
    logic                        typed;
    group_res_t                  want;
  } frame_row_t;

  // block ports
  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        cfg_wr_en   = 1'b0;
  logic [ppd_pkg::MW_BITS-1:0] cfg_wr_data = '0;
  logic signed [LB-1:0]        logit       = '0;
  logic                        is_last     = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_ready;
  logic [MB-1:0]               mean_frame;
  logic                        has_peak;
  logic                        final_res;
  logic                        out_valid;
  logic                        out_ready   = 1'b0;

  // peak tracker state
  logic signed [LB-1:0]        win_val [WIN_LEN];
  logic [WIN_LEN-1:0]          win_ok;
  logic [FB-1:0]               next_frame;
  logic [MB-1:0]               grp_mean;
  logic [FB-1:0]               grp_cnt;
  logic                        grp_open;
  logic [ppd_pkg::MW_BITS-1:0] merge_dist;

  group_res_t due_groups [$];
  group_res_t new_groups [$];
  frame_row_t dir_rows [$];

  int   errors      = 0;
  int   frames_sent = 0;
  int   tx_run      = 0;
  int   rx_run      = 0;
  logic eager       = 1'b0;
  logic hold_go     = 1'b0;
  logic rx_hold     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  peak_pick_dedup DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .logit       (logit),
    .is_last     (is_last),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mean_frame  (mean_frame),
    .has_peak    (has_peak),
    .final_res   (final_res),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
  );

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // start of a new sequence: empty window, no group
  task automatic clear_track();
    for (int k = 0; k < WIN_LEN; k++) win_val[k] = '0;
    win_ok     = '0;
    next_frame = '0;
    grp_mean   = '0;
    grp_cnt    = '0;
    grp_open   = 1'b0;
  endtask

  task automatic add_group(input logic [MB-1:0] mean, input logic pk, input logic fin);
    group_res_t g;
    g.mean = mean;
    g.peak = pk;
    g.fin  = fin;
    new_groups = {new_groups, g};
  endtask

  task automatic shift_frame(input logic signed [LB-1:0] v, input logic ok);
    for (int k = WIN_LEN - 1; k > 0; k--) win_val[k] = win_val[k-1];
    win_val[0] = v;
    win_ok     = {win_ok[WIN_LEN-2:0], ok};
  endtask

  // join the open group or close it and start a new one
  task automatic merge_peak(input logic [FB-1:0] frm);
    logic [MB-1:0] pq;
    longint pq_l, mean_l, cnt_l, lim, diff, mag, q;
    pq = {frm, {FR{1'b0}}};
    if (!grp_open) begin
      grp_mean = pq;
      grp_cnt  = FB'(1);
      grp_open = 1'b1;
    end else begin
      pq_l   = pq;
      mean_l = grp_mean;
      lim    = merge_dist;
      lim    = lim << FR;
      diff   = pq_l - mean_l;
      if (diff <= lim) begin
        if (grp_cnt != {FB{1'b1}}) grp_cnt = grp_cnt + 1'b1;
        cnt_l = grp_cnt;
        mag   = (diff < 0) ? -diff : diff;
        q     = mag / cnt_l;
        if (diff < 0) q = -q;
        mean_l   = mean_l + q;
        grp_mean = mean_l[MB-1:0];
      end else begin
        add_group(grp_mean, 1'b1, 1'b0);
        grp_mean = pq;
        grp_cnt  = FB'(1);
      end
    end
  endtask

  // centre slot is a peak when positive and not below any valid neighbor
  task automatic judge_centre(input logic [FB-1:0] frm);
    logic is_max;
    is_max = win_ok[WR] && (win_val[WR] > 0);
    for (int k = 0; k < WIN_LEN; k++) begin
      if (win_ok[k] && (win_val[k] > win_val[WR])) is_max = 1'b0;
    end
    if (is_max) merge_peak(frm);
  endtask

  // groups closed by one frame, end of sequence flushes the window
  task automatic pick_frame(input logic signed [LB-1:0] lg, input logic lst);
    logic [FB-1:0] pos;
    new_groups.delete();
    pos = next_frame;
    shift_frame(lg, 1'b1);
    next_frame = next_frame + 1'b1;
    judge_centre(pos - FB'(WR));
    if (lst) begin
      for (int j = 1; j <= WR; j++) begin
        shift_frame('0, 1'b0);
        judge_centre(pos + FB'(j) - FB'(WR));
      end
      if (grp_open) add_group(grp_mean, 1'b1, 1'b1);
      else add_group('0, 1'b0, 1'b1);
      clear_track();
    end
  endtask

  // idle cycles per transfer, with runs of back-to-back transfers
  task automatic draw_wait(inout int run_left, output int cycles);
    if (run_left > 0) begin
      run_left--;
      cycles = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(10, 30);
      cycles   = 0;
    end else begin
      cycles = $urandom_range(0, 13);
    end
  endtask

  function automatic int pick_level();
    case ($urandom_range(0, 9))
      0:       return 32767;
      1:       return -32768;
      2, 3, 4: return $urandom_range(1, 600);
      5:       return 0;
      default: return -int'($urandom_range(1, 400));
    endcase
  endfunction

  task automatic add_row(input logic cfg, input int mw, input int lg, input logic lst,
                         input logic typed, input int em, input logic eh, input logic ef);
    frame_row_t r;
    r.cfg       = cfg;
    r.mw        = mw[ppd_pkg::MW_BITS-1:0];
    r.lg        = lg[LB-1:0];
    r.lst       = lst;
    r.typed     = typed;
    r.want.mean = em[MB-1:0];
    r.want.peak = eh;
    r.want.fin  = ef;
    dir_rows = {dir_rows, r};
  endtask

  // one input transfer, then the expected groups it closes
  task automatic offer_frame(input logic [LB-1:0] lg, input logic lst, input logic typed,
                             input group_res_t want);
    int gap;
    draw_wait(tx_run, gap);
    if (eager) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    logit    <= lg;
    is_last  <= lst;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
    pick_frame(lg, lst);
    if (typed) due_groups = {due_groups, want};
    else foreach (new_groups[i]) due_groups = {due_groups, new_groups[i]};
  endtask

  // register write only once the block has drained
  task automatic write_merge_width(input logic [ppd_pkg::MW_BITS-1:0] v);
    in_valid <= 1'b0;
    while (due_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    merge_dist = v;
  endtask

  task automatic check_group();
    group_res_t want;
    if (due_groups.size() == 0) begin
      report_mismatch($sformatf("unexpected result mean_frame=%0h has_peak=%0b final_res=%0b",
                                mean_frame, has_peak, final_res));
    end else begin
      want = due_groups.pop_front();
      if (mean_frame !== want.mean)
        report_mismatch($sformatf("mean_frame %0h, expected %0h", mean_frame, want.mean));
      if (has_peak !== want.peak)
        report_mismatch($sformatf("has_peak %0b, expected %0b", has_peak, want.peak));
      if (final_res !== want.fin)
        report_mismatch($sformatf("final_res %0b, expected %0b", final_res, want.fin));
    end
  endtask

  // output side: random stalls, checks every transfer
  initial begin : drain_results
    int gap;
    while (rst) @(posedge clk);
    forever begin
      draw_wait(rx_run, gap);
      if (gap != 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_group();
    end
  end

  // long receiver hold-off so the event queue fills and input stalls
  initial begin : hold_off
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : stimulus
    frame_row_t       row;
    group_res_t       none;
    int               seq_len, style, run_left, pick;
    logic [LB-1:0]    run_val, lg;
    logic [31:0]      rnd;
    none       = '0;
    run_val    = '0;
    merge_dist = ppd_pkg::MERGE_WIDTH_RESET;
    clear_track();

    // single-frame sequences: extremes, zero, smallest positive
    add_row(1'b0, 0, -32768, 1'b1, 1'b1, 0, 1'b0, 1'b1);
    add_row(1'b0, 0,  32767, 1'b1, 1'b1, 0, 1'b1, 1'b1);
    add_row(1'b0, 0,      0, 1'b1, 1'b1, 0, 1'b0, 1'b1);
    add_row(1'b0, 0,      1, 1'b1, 1'b1, 0, 1'b1, 1'b1);
    // plateau of three peaks, merge then split at width 1
    add_row(1'b1, 1,    256, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    256, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    256, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,     -1, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // five-frame plateau all merged at widest setting
    add_row(1'b1, 15,   100, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    100, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    100, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    100, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    100, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // separate peaks at width 0, last frame itself a peak
    add_row(1'b1, 0,    300, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,   -300, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,   -300, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,   -300, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,   -300, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,    300, 1'b1, 1'b0, 0, 1'b0, 1'b0);
    // adjacent equal peaks never merge at width 0
    add_row(1'b0, 0,     50, 1'b0, 1'b0, 0, 1'b0, 1'b0);
    add_row(1'b0, 0,     50, 1'b1, 1'b0, 0, 1'b0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg) write_merge_width(row.mw);
      offer_frame(row.lg, row.lst, row.typed, row.want);
    end

    // back-to-back end markers against a stalled receiver
    hold_go = 1'b1;
    eager   = 1'b1;
    repeat (BURST_FRAMES) offer_frame(LB'(1), 1'b1, 1'b0, none);
    eager = 1'b0;

    // random sequences: mostly plateaus and spikes, some full-range noise
    while (frames_sent < dir_rows.size() + BURST_FRAMES + RANDOM_FRAMES) begin
      if ($urandom_range(0, 3) == 0)
        write_merge_width(ppd_pkg::MW_BITS'($urandom_range(0, 15)));
      style    = $urandom_range(0, 3);
      seq_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
      run_left = 0;
      for (int n = 0; n < seq_len; n++) begin
        if (style == 0) begin
          rnd = $urandom();
          lg  = rnd[LB-1:0];
        end else begin
          if (run_left == 0) begin
            pick     = pick_level();
            run_val  = pick[LB-1:0];
            run_left = $urandom_range(1, 4);
          end
          lg = run_val;
          run_left--;
        end
        offer_frame(lg, n == seq_len - 1, 1'b0, none);
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (due_groups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** peak_pick_dedup: PASSED **");
    end else begin
      $display("** peak_pick_dedup: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** peak_pick_dedup: FAILED **");
    $finish;
  end

endmodule
